FILE: design/rsaks_pkg.sv
// Shared types and constants for the RSA key setup block.
`timescale 1ns / 1ps
`default_nettype none
package rsaks_pkg;

    // Arithmetic key width; operands and results wrap modulo 2^KEY_W.
    localparam int KEY_W = 128;
    localparam int CNT_W = $clog2(KEY_W);

    typedef logic [KEY_W-1:0] t_key;

    // Operation codes of the shared arithmetic unit.
    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_COPRIME = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_N_GO,
        S_N_WAIT,
        S_PHI_GO,
        S_PHI_WAIT,
        S_CHECK,
        S_LOOP,
        S_DIV_WAIT,
        S_MUL_GO,
        S_MUL_WAIT,
        S_FINAL,
        S_INV_WAIT,
        S_DONE
    } t_state;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        t_op  op;
        t_key a;
        t_key b;
    } t_arith_req;

    // Response from the arithmetic unit.
    typedef struct packed {
        logic done;
        t_key lo;
        t_key rem;
    } t_arith_rsp;

endpackage
`default_nettype wire

FILE: design/rsaks_arith.sv
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsaks_arith (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rsaks_pkg::t_arith_req i_req,
    output rsaks_pkg::t_arith_rsp     o_rsp
);
    import rsaks_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_op              r_op, n_op;
    t_key             r_a, n_a;
    t_key             r_b, n_b;
    t_key             r_acc, n_acc;
    t_key             r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [KEY_W:0]   trial;
    logic [KEY_W:0]   diff;

    // One step of either operation.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        trial  = {r_rem, r_a[KEY_W-1]};
        diff   = trial - {1'b0, r_b};
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
            n_rem  = '0;
            n_cnt  = CNT_W'(KEY_W - 1);
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                // Shift-add multiply, low KEY_W bits kept.
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[KEY_W-2:0], 1'b0};
                n_b = {1'b0, r_b[KEY_W-1:1]};
            end else begin
                // Restoring divide: bring down one dividend bit.
                n_a = {r_a[KEY_W-2:0], 1'b0};
                if (!diff[KEY_W]) begin
                    n_rem = diff[KEY_W-1:0];
                    n_acc = {r_acc[KEY_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[KEY_W-1:0];
                    n_acc = {r_acc[KEY_W-2:0], 1'b0};
                end
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.lo   = r_acc;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

FILE: design/rsaks_ctrl.sv
// Sequencer for modulus, phi, range check and extended Euclid.
`timescale 1ns / 1ps
`default_nettype none
module rsaks_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [63:0]           i_p,
    input  wire logic [63:0]           i_q,
    input  wire logic [127:0]          i_e,
    input  wire logic                  i_res_ready,
    input  wire rsaks_pkg::t_arith_rsp i_rsp,
    output rsaks_pkg::t_arith_req      o_req,
    output logic                       o_busy,
    output logic                       o_done,
    output rsaks_pkg::t_key            o_n,
    output rsaks_pkg::t_key            o_d,
    output rsaks_pkg::t_status         o_status
);
    import rsaks_pkg::*;

    t_state  r_state, n_state;
    t_key    r_p, r_q, r_e, r_n, r_phi;
    t_key    r_ra, r_rb, r_ta, r_tb, r_qt, r_rm, r_d;
    logic    r_nega, r_negb;
    t_status r_status;
    t_key    one;

    assign one = t_key'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_start) n_state = S_N_GO;
            S_N_GO:     n_state = S_N_WAIT;
            S_N_WAIT:   if (i_rsp.done) n_state = S_PHI_GO;
            S_PHI_GO:   n_state = S_PHI_WAIT;
            S_PHI_WAIT: if (i_rsp.done) n_state = S_CHECK;
            S_CHECK: begin
                if (r_e > one && r_e < r_n) n_state = S_LOOP;
                else n_state = S_DONE;
            end
            S_LOOP: begin
                if (r_rb != '0) n_state = S_DIV_WAIT;
                else n_state = S_FINAL;
            end
            S_DIV_WAIT: if (i_rsp.done) n_state = S_MUL_GO;
            S_MUL_GO:   n_state = S_MUL_WAIT;
            S_MUL_WAIT: if (i_rsp.done) n_state = S_LOOP;
            S_FINAL: begin
                if (r_ra == one && r_phi != '0) n_state = S_INV_WAIT;
                else n_state = S_DONE;
            end
            S_INV_WAIT: if (i_rsp.done) n_state = S_DONE;
            S_DONE:     if (i_res_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Requests to the arithmetic unit and status outputs.
    always_comb begin
        o_req.start = 1'b0;
        o_req.op    = OP_MUL;
        o_req.a     = r_p;
        o_req.b     = r_q;
        o_busy      = (r_state != S_IDLE);
        o_done      = (r_state == S_DONE);
        case (r_state)
            S_N_GO: begin
                o_req.start = 1'b1;
            end
            S_PHI_GO: begin
                o_req.start = 1'b1;
                o_req.a     = r_p - one;
                o_req.b     = r_q - one;
            end
            S_LOOP: begin
                o_req.start = (r_rb != '0);
                o_req.op    = OP_DIV;
                o_req.a     = r_ra;
                o_req.b     = r_rb;
            end
            S_MUL_GO: begin
                o_req.start = 1'b1;
                o_req.a     = r_qt;
                o_req.b     = r_tb;
            end
            S_FINAL: begin
                o_req.start = (r_ra == one && r_phi != '0);
                o_req.op    = OP_DIV;
                o_req.a     = r_ta;
                o_req.b     = r_phi;
            end
            default: begin
                o_req.start = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p      <= KEY_W'(i_p);
                r_q      <= KEY_W'(i_q);
                r_e      <= KEY_W'(i_e);
                r_d      <= '0;
                r_status <= ST_OK;
            end
            S_N_WAIT: if (i_rsp.done) r_n <= i_rsp.lo;
            S_PHI_WAIT: if (i_rsp.done) r_phi <= i_rsp.lo;
            S_CHECK: begin
                if (!(r_e > one && r_e < r_n)) r_status <= ST_RANGE;
                r_ra   <= r_phi;
                r_rb   <= r_e;
                r_ta   <= '0;
                r_tb   <= one;
                r_nega <= 1'b0;
                r_negb <= 1'b0;
            end
            S_DIV_WAIT: begin
                if (i_rsp.done) begin
                    r_qt <= i_rsp.lo;
                    r_rm <= i_rsp.rem;
                end
            end
            S_MUL_WAIT: begin
                // Euclid step: shift remainders and coefficients along.
                if (i_rsp.done) begin
                    r_ra   <= r_rb;
                    r_rb   <= r_rm;
                    r_ta   <= r_tb;
                    r_tb   <= r_ta + i_rsp.lo;
                    r_nega <= r_negb;
                    r_negb <= !r_negb;
                end
            end
            S_FINAL: begin
                if (!(r_ra == one && r_phi != '0)) r_status <= ST_COPRIME;
            end
            S_INV_WAIT: begin
                // Fold a negative coefficient back into [0, phi).
                if (i_rsp.done) begin
                    if (r_nega && i_rsp.rem != '0) r_d <= r_phi - i_rsp.rem;
                    else r_d <= i_rsp.rem;
                end
            end
            default: begin
                r_d <= r_d;
            end
        endcase
    end

    assign o_n      = r_n;
    assign o_d      = r_d;
    assign o_status = r_status;

endmodule
`default_nettype wire

FILE: design/rsa_key_setup_top.sv
// Top level of the RSA key setup block: handshake and result register.
//
// Input channel: i_in_valid with o_in_stall carries p, q and the two halves
// of the public exponent e. A transfer happens on a rising edge with valid
// high and stall low. Output channel: o_out_valid with i_out_stall carries
// n, the private exponent d and a status code; one result per input.
// o_in_stall is high while an item is being worked on.
// Sequence: two multiplies for n and phi, then per Euclid step one divide
// and one multiply, and one final divide for the reduction of d. A range
// error skips the Euclid loop and the final divide. All of it runs on the
// one shared bit-serial unit.
// Throughput: one item at a time; the next input may be taken while the
// previous result waits in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid. While the receiver stalls, the result holds steady and the
// sequencer waits in its final state before writing a new result.
`timescale 1ns / 1ps
`default_nettype none
module rsa_key_setup_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_first_factor,
    input  wire logic [63:0] i_second_factor,
    input  wire logic [63:0] i_exponent_low,
    input  wire logic [63:0] i_exponent_high,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_modulus_low,
    output logic [63:0]      o_modulus_high,
    output logic [63:0]      o_inverse_low,
    output logic [63:0]      o_inverse_high,
    output logic [1:0]       o_status
);
    import rsaks_pkg::*;

    t_arith_req  req;
    t_arith_rsp  rsp;
    logic        busy, done, res_ready, start;
    t_key        n_val, d_val;
    t_status     st_val;
    logic        r_out_valid;
    logic [127:0] r_mod, r_inv;
    t_status     r_status;

    assign start     = i_in_valid && !busy;
    assign res_ready = !r_out_valid || !i_out_stall;

    rsaks_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    rsaks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_p         (i_first_factor),
        .i_q         (i_second_factor),
        .i_e         ({i_exponent_high, i_exponent_low}),
        .i_res_ready (res_ready),
        .i_rsp       (rsp),
        .o_req       (req),
        .o_busy      (busy),
        .o_done      (done),
        .o_n         (n_val),
        .o_d         (d_val),
        .o_status    (st_val)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (done && res_ready) begin
            r_mod    <= 128'(n_val);
            r_inv    <= 128'(d_val);
            r_status <= st_val;
        end
    end

    assign o_in_stall     = busy;
    assign o_out_valid    = r_out_valid;
    assign o_modulus_low  = r_mod[63:0];
    assign o_modulus_high = r_mod[127:64];
    assign o_inverse_low  = r_inv[63:0];
    assign o_inverse_high = r_inv[127:64];
    assign o_status       = r_status;

endmodule
`default_nettype wire

FILE: sim/tb_rsa_key_setup_top.sv
// Testbench for the RSA key setup block: random and directed keys checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected key results and compares each transfer against the oldest one.
class key_scoreboard;
    typedef struct {
        logic [127:0] modulus;
        logic [127:0] inverse;
        logic [1:0]   status;
    } key_result_t;

    key_result_t pending_keys[$];
    int          error_count;
    int          checked_count;

    // Works out n, phi and d for one key request and queues the result.
    function void note_request(logic [63:0] p, logic [63:0] q, logic [127:0] e);
        key_result_t  res;
        logic [127:0] phi, ra, rb, ta, tb, tn, qt, rm;
        logic         neg_a, neg_b;
        res.modulus = {64'd0, p} * {64'd0, q};
        phi = ({64'd0, p} - 128'd1) * ({64'd0, q} - 128'd1);
        res.inverse = '0;
        res.status = rsaks_pkg::ST_OK;
        if (!(e > 128'd1 && e < res.modulus)) begin
            res.status = rsaks_pkg::ST_RANGE;
        end else begin
            // Extended Euclid with coefficient magnitudes and alternating signs.
            ra = phi;
            rb = e;
            ta = '0;
            tb = 128'd1;
            neg_a = 1'b0;
            neg_b = 1'b0;
            while (rb != 0) begin
                qt = ra / rb;
                rm = ra % rb;
                ra = rb;
                rb = rm;
                tn = ta + qt * tb;
                ta = tb;
                tb = tn;
                neg_a = neg_b;
                neg_b = !neg_b;
            end
            if (ra != 128'd1 || phi == 0) begin
                res.status = rsaks_pkg::ST_COPRIME;
            end else begin
                rm = ta % phi;
                res.inverse = (neg_a && rm != 0) ? phi - rm : rm;
            end
        end
        pending_keys.push_back(res);
    endfunction

    // Compares one output transfer with the oldest expectation.
    function void check_result(logic [127:0] modulus, logic [127:0] inverse, logic [1:0] status);
        key_result_t exp_res;
        if (pending_keys.size() == 0) begin
            $error("unexpected result: modulus %h", modulus);
            error_count++;
            return;
        end
        exp_res = pending_keys.pop_front();
        checked_count++;
        if (modulus[63:0] !== exp_res.modulus[63:0]) begin
            $error("modulus_low: expected %h, got %h", exp_res.modulus[63:0], modulus[63:0]);
            error_count++;
        end
        if (modulus[127:64] !== exp_res.modulus[127:64]) begin
            $error("modulus_high: expected %h, got %h", exp_res.modulus[127:64],
                   modulus[127:64]);
            error_count++;
        end
        if (inverse[63:0] !== exp_res.inverse[63:0]) begin
            $error("inverse_low: expected %h, got %h", exp_res.inverse[63:0], inverse[63:0]);
            error_count++;
        end
        if (inverse[127:64] !== exp_res.inverse[127:64]) begin
            $error("inverse_high: expected %h, got %h", exp_res.inverse[127:64],
                   inverse[127:64]);
            error_count++;
        end
        if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            error_count++;
        end
    endfunction
endclass

module tb_rsa_key_setup_top;
    import rsaks_pkg::*;

    localparam int CYCLE_LIMIT = 40_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_first_factor;
    logic [63:0] i_second_factor;
    logic [63:0] i_exponent_low;
    logic [63:0] i_exponent_high;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_modulus_low;
    logic [63:0] o_modulus_high;
    logic [63:0] o_inverse_low;
    logic [63:0] o_inverse_high;
    logic [1:0]  o_status;

    key_scoreboard key_board;
    int            cycle_count;
    int            sent_count;
    logic [63:0]   small_primes[$] = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd61,
                                       64'd65537, 64'd1000003, 64'd4294967311,
                                       64'd18446744073709551557};

    rsa_key_setup_top DUT (.*);

    // Free-running clock, 20 ns period.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Random gap length: mostly short, now and then long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Presents one key request and holds it until the transfer.
    // Called at a falling edge; valid stays high for a back-to-back request.
    task automatic send_key(logic [63:0] p, logic [63:0] q, logic [127:0] e);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_first_factor  <= p;
        i_second_factor <= q;
        i_exponent_low  <= e[63:0];
        i_exponent_high <= e[127:64];
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        key_board.note_request(p, q, e);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits at falling edges until every expected result has come.
    task automatic drain_keys();
        i_in_valid <= 1'b0;
        while (key_board.pending_keys.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_prime();
        return small_primes[$urandom_range(0, small_primes.size() - 1)];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Receiver side: random stalls, results checked at the rising edge.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = gap_length();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            key_board.check_result({o_modulus_high, o_modulus_low},
                                   {o_inverse_high, o_inverse_low}, o_status);
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_rsa_key_setup_top: errors");
            $finish;
        end
    end

    // Stimulus: directed corner cases, then random keys.
    initial begin
        logic [63:0]  p, q;
        logic [127:0] e;
        int           kind;
        key_board = new();
        cycle_count = 0;
        sent_count = 0;
        i_in_valid = 1'b0;
        i_first_factor = '0;
        i_second_factor = '0;
        i_exponent_low = '0;
        i_exponent_high = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Textbook key, exponent range edges and coprimality failure.
        send_key(64'd61, 64'd53, 128'd17);
        send_key(64'd61, 64'd53, 128'd0);
        send_key(64'd61, 64'd53, 128'd1);
        send_key(64'd61, 64'd53, 128'd3233);
        send_key(64'd61, 64'd53, 128'd3232);
        send_key(64'd61, 64'd53, 128'd2);
        send_key(64'd61, 64'd53, 128'd13);
        // Zero factors wrap p-1; zero phi; phi of one.
        send_key(64'd0, 64'd7, 128'd3);
        send_key(64'd0, 64'd0, 128'd3);
        send_key(64'd1, 64'd13, 128'd5);
        send_key(64'd2, 64'd2, 128'd3);
        send_key(64'd2, 64'd3, 128'd5);
        // Full-width values and all-ones exponent halves.
        send_key('1, '1, 128'd65537);
        send_key('1, '1, {64'hFFFF_FFFF_FFFF_FFFD, 64'hFFFF_FFFF_FFFF_FFFF});
        send_key(64'd18446744073709551557, 64'd18446744073709551533, '1);
        send_key(64'd18446744073709551557, 64'd4294967311,
                 {64'h0000_0000_1234_5678, 64'h9ABC_DEF0_1357_9BDF});
        send_key(64'd15, 64'd21, 128'd11);

        // Drain completely before continuing.
        drain_keys();
        repeat (300) @(negedge i_clk);

        for (int i = 0; i < 100; i++) begin
            kind = $urandom_range(0, 9);
            p = (kind < 6) ? pick_prime() : rand64();
            q = (kind < 6) ? pick_prime() : rand64();
            if (kind < 7) begin
                // Odd exponent reduced modulo n | 4, mostly valid keys.
                e = {64'd0, 64'd0};
                e = ({rand64(), rand64()} % (({64'd0, p} * {64'd0, q}) | 128'd4)) | 128'd1;
            end else if (kind == 7) begin
                e = {rand64(), rand64()};
            end else if (kind == 8) begin
                e = {64'd0, 64'd65537};
            end else begin
                e = 128'($urandom_range(0, 3));
            end
            send_key(p, q, e);
            if (i == 50) drain_keys();
        end

        drain_keys();
        repeat (300) @(negedge i_clk);
        $display("Covered %0d keys: range and coprimality errors, wrapped and full-width factors,",
                 sent_count);
        $display("and %0d results checked under random input gaps and output stalls.",
                 key_board.checked_count);
        if (key_board.error_count == 0 && key_board.pending_keys.size() == 0) begin
            $display("tb_rsa_key_setup_top: clean");
        end else begin
            $display("tb_rsa_key_setup_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
